### rtl/core/sfdl_pkg.sv
// Shared constants and types for the status frame deframer and link watchdog.
`timescale 1ns / 1ps

package sfdl_pkg;

  // Frame layout: sync, length, payload bytes, XOR checksum.
  localparam logic [7:0] SYNC_MARK     = 8'hAA;
  localparam int         PAYLOAD_LEN   = 7;
  localparam int         POS_W         = 3;
  localparam logic [7:0] LEN_BYTE      = 8'(PAYLOAD_LEN);

  // Watchdog widths and limits.
  localparam int          TIMEOUT_W     = 16;
  localparam int          SILENCE_W     = 17;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [16:0] SILENCE_MAX   = 17'h1FFFF;

  // Input item kinds carried on tuser.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Held indicator bytes, mode_0 in the lowest byte.
  typedef logic [PAYLOAD_LEN-1:0][7:0] modes_t;

  // Per-beat outcome of the frame parser.
  typedef struct packed {
    logic   frame_ok;
    modes_t modes;
  } parse_result_t;

endpackage

### rtl/core/sfdl_parser.sv
// Frame parser: hunts for sync, checks length and XOR checksum, holds the mode bytes.
`timescale 1ns / 1ps

module sfdl_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_step,
  input  logic [7:0]             data_byte,
  output sfdl_pkg::parse_result_t result
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY,
    PH_CHECK
  } phase_t;

  phase_t                     phase, phase_next;
  logic [sfdl_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]                 running_xor, running_xor_next;
  logic [7:0]                 pending [sfdl_pkg::PAYLOAD_LEN];
  sfdl_pkg::modes_t           held_modes;
  logic                       good;
  logic                       pending_we;
  logic [sfdl_pkg::POS_W-1:0] pos_inc;

  assign pos_inc = byte_position + sfdl_pkg::POS_W'(1);

  // Next-state decode for one received byte.
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    running_xor_next   = running_xor;
    good               = 1'b0;
    pending_we         = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (data_byte == sfdl_pkg::SYNC_MARK) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (data_byte == sfdl_pkg::LEN_BYTE) begin
          phase_next         = PH_BODY;
          byte_position_next = '0;
          running_xor_next   = '0;
        end else if (data_byte == sfdl_pkg::SYNC_MARK) begin
          phase_next = PH_LEN;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        pending_we         = (byte_position < sfdl_pkg::POS_W'(sfdl_pkg::PAYLOAD_LEN));
        running_xor_next   = running_xor ^ data_byte;
        byte_position_next = pos_inc;
        if (pos_inc >= sfdl_pkg::POS_W'(sfdl_pkg::PAYLOAD_LEN)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        good               = (data_byte == running_xor);
        phase_next         = PH_HUNT;
        byte_position_next = '0;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
      running_xor   <= '0;
      held_modes    <= '0;
    end else if (byte_step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      running_xor   <= running_xor_next;
      if (good) begin
        for (int i = 0; i < sfdl_pkg::PAYLOAD_LEN; i++) begin
          held_modes[i] <= pending[i];
        end
      end
    end
  end

  // Payload bytes of the frame in progress; every entry is written before use.
  always_ff @(posedge clk) begin
    if (byte_step && pending_we) begin
      pending[byte_position] <= data_byte;
    end
  end

  // Outcome of this beat, with the modes as they stand after it.
  always_comb begin
    result.frame_ok = byte_step && good;
    result.modes    = held_modes;
    if (byte_step && good) begin
      for (int i = 0; i < sfdl_pkg::PAYLOAD_LEN; i++) begin
        result.modes[i] = pending[i];
      end
    end
  end

  // The checksum phase is only reached once all payload bytes are in.
  a_check_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHECK |-> byte_position == sfdl_pkg::POS_W'(sfdl_pkg::PAYLOAD_LEN))
    else $error("checksum phase with incomplete payload");

  // A good frame always sends the parser back to hunting.
  a_good_hunt: assert property (@(posedge clk) disable iff (rst)
    result.frame_ok |=> phase == PH_HUNT)
    else $error("parser did not return to hunt after a good frame");

  // The held modes change only on a good frame.
  a_modes_hold: assert property (@(posedge clk) disable iff (rst)
    !result.frame_ok |=> $stable(held_modes))
    else $error("held modes changed without a good frame");

endmodule

### rtl/core/sfdl_watchdog.sv
// Link watchdog: saturating silence counter against the programmed timeout.
`timescale 1ns / 1ps

module sfdl_watchdog (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           timeout_we,
  input  logic [sfdl_pkg::TIMEOUT_W-1:0] timeout_wdata,
  input  logic                           tick_step,
  input  logic                           frame_good,
  output logic                           link_lost
);

  logic [sfdl_pkg::TIMEOUT_W-1:0] timeout_ms;
  logic [sfdl_pkg::SILENCE_W-1:0] silence_count, silence_count_next;

  // Count ticks up to saturation; a good frame clears the count.
  always_comb begin
    silence_count_next = silence_count;
    if (tick_step && (silence_count < sfdl_pkg::SILENCE_MAX)) begin
      silence_count_next = silence_count + sfdl_pkg::SILENCE_W'(1);
    end else if (frame_good) begin
      silence_count_next = '0;
    end
  end

  assign link_lost = silence_count_next > {1'b0, timeout_ms};

  // Timeout register and silence counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms    <= sfdl_pkg::TIMEOUT_RESET;
      silence_count <= '0;
    end else begin
      if (timeout_we) begin
        timeout_ms <= timeout_wdata;
      end
      silence_count <= silence_count_next;
    end
  end

  // A good frame leaves the counter at zero.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    frame_good |=> silence_count == '0)
    else $error("silence count not cleared by a good frame");

  // A tick below saturation advances the counter by exactly one.
  a_step: assert property (@(posedge clk) disable iff (rst)
    tick_step && silence_count < sfdl_pkg::SILENCE_MAX
      |=> silence_count == $past(silence_count) + sfdl_pkg::SILENCE_W'(1))
    else $error("silence count did not advance on a tick");

  // Without a tick or a good frame the counter holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !tick_step && !frame_good |=> $stable(silence_count))
    else $error("silence count moved without cause");

endmodule

### rtl/core/status_frame_deframer_link_watchdog_unit.sv
// Top level: input register, parser and watchdog, and the result register.
`timescale 1ns / 1ps

// Deframes status frames (sync 0xAA, length 7, seven mode bytes, XOR checksum)
// from a byte stream interleaved with millisecond ticks, and flags link loss
// when more ticks than timeout_ms pass without a good frame. Every input beat
// gives exactly one output beat carrying frame_ok, link_lost and the seven
// held mode bytes. The block takes one beat per clock cycle unless m_tready
// holds the output back; each beat passes an input register and then a result
// register before its result is offered on the output. The parser and counter
// update between those registers sets that rate. timeout_ms resets
// to 2000 and should be written only while no beat is in flight.
module status_frame_deframer_link_watchdog_unit (
  input  logic        clk,
  input  logic        rst,
  // Timeout register write
  input  logic        timeout_we,
  input  logic [15:0] timeout_wdata,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] command: 0 byte, 1 tick
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] mode_0 up to [55:48] mode_6
  output logic [1:0]  m_tuser    // [0] frame_ok, [1] link_lost
);

  logic                    in_valid;
  logic                    in_cmd;
  logic [7:0]              in_byte;
  logic                    out_valid;
  logic                    advance;
  logic                    step;
  logic                    byte_step;
  logic                    tick_step;
  logic                    link_lost;
  sfdl_pkg::parse_result_t parse_res;

  // Pipeline handshake: the input register moves on whenever the result slot frees.
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign step      = in_valid && advance;
  assign byte_step = step && (in_cmd == sfdl_pkg::CMD_BYTE);
  assign tick_step = step && (in_cmd == sfdl_pkg::CMD_TICK);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  sfdl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_step (byte_step),
    .data_byte (in_byte),
    .result    (parse_res)
  );

  sfdl_watchdog u_watchdog (
    .clk           (clk),
    .rst           (rst),
    .timeout_we    (timeout_we),
    .timeout_wdata (timeout_wdata),
    .tick_step     (tick_step),
    .frame_good    (parse_res.frame_ok),
    .link_lost     (link_lost)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= parse_res.modes;
      m_tuser <= {link_lost, parse_res.frame_ok};
    end
  end

  assign m_tvalid = out_valid;

  // A good frame clears the silence count, so it never reports link loss.
  a_ok_not_lost: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("good frame reported together with link loss");

  // Back-pressure only arises from a full pipeline with a stalled output.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled with room in the pipeline");

  // A tick never reports a completed frame.
  a_tick_no_frame: assert property (@(posedge clk) disable iff (rst)
    tick_step |=> !m_tuser[0])
    else $error("frame reported for a tick");

endmodule
